>>> hdl/rlcs_pkg.sv
// Shared types, codes and helpers for the RGB LED chain serializer.
`default_nettype none

package rlcs_pkg;

    localparam int COLOR_W   = 24;
    localparam int TICK_W    = 24;
    localparam int DUR_W     = 16;
    localparam int BIT_CNT_W = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [BIT_CNT_W-1:0] BIT_LAST = 5'd23;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        REQ_SET_PIXEL = 2'd0,
        REQ_SET_ALL   = 2'd1,
        REQ_SHOW      = 2'd2,
        REQ_TICK      = 2'd3
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH      = 2'd3;

    // a zero duration counts as one tick
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        at_least_one = (v == '0) ? TICK_W'(1) : v;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [15:0] v);
        if (v[15])
            clamp8 = 8'd0;
        else if (v[14:8] != '0)
            clamp8 = 8'hFF;
        else
            clamp8 = v[7:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/rlcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rlcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 3
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/rgb_led_chain_serializer.sv
// Top level: color store in RAM and one-wire bit timing for an RGB LED chain.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  request  | i_in_valid / o_in_ready   | i_req_type i_pixel_index i_red i_green i_blue
//  result   | o_out_valid / i_out_ready | o_line_level o_busy_res o_accepted
//  config   | i_cfg_we                  | i_cfg_idx i_cfg_data
//
// One request beat per clock; a stalled result beat blocks new requests only until it
// is taken. Every request finishes in the cycle it is taken and its result beat sits
// in the output register the next cycle. The next pixel's color is prefetched from
// the RAM during the current pixel, so a pixel change never waits on the RAM. Reset
// clears the store at once through per-entry valid bits; no clearing pass.
`default_nettype none

module rgb_led_chain_serializer #(
    parameter int LED_COUNT = 3
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [1:0]                          i_req_type,
    input  wire logic [7:0]                          i_pixel_index,
    input  wire logic signed [15:0]                  i_red,
    input  wire logic signed [15:0]                  i_green,
    input  wire logic signed [15:0]                  i_blue,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic                                     o_line_level,
    output logic                                     o_busy_res,
    output logic                                     o_accepted,
    input  wire logic                                i_cfg_we,
    input  wire logic [rlcs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rlcs_pkg::TICK_W-1:0]         i_cfg_data
);

    import rlcs_pkg::*;

    localparam int ADDR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [8:0] LED_CNT = 9'(LED_COUNT);

    // configuration
    logic [DUR_W-1:0]  r_short_high;
    logic [DUR_W-1:0]  r_long_high;
    logic [DUR_W-1:0]  r_long_low;
    logic [TICK_W-1:0] r_latch;

    // store bookkeeping: invalid entries read as the last set-all color
    logic [LED_COUNT-1:0] r_valid, n_valid;
    logic [COLOR_W-1:0]   r_global, n_global;
    logic [COLOR_W-1:0]   r_first, n_first;
    logic [COLOR_W-1:0]   r_next;
    logic                 r_rd_pend;
    logic [ADDR_W-1:0]    r_rd_addr;

    // serializer state
    t_phase               r_phase, n_phase;
    logic [TICK_W-1:0]    r_tick, n_tick;
    logic [COLOR_W-1:0]   r_shift, n_shift;
    logic [BIT_CNT_W-1:0] r_bit, n_bit;
    logic [7:0]           r_pix, n_pix;

    // result register
    logic r_out_valid, r_out_line, r_out_busy, r_out_acc;
    logic n_line, n_busy, n_acc;

    // RAM ports
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [COLOR_W-1:0] ram_wdata, ram_rdata;

    logic               accept;
    t_req               req;
    logic [COLOR_W-1:0] pix_word, all_word, start_word, shifted;
    logic [8:0]         pix_plus1, pix_plus2;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign req        = t_req'(i_req_type);

    assign pix_word  = {i_green[7:0], i_red[7:0], i_blue[7:0]};
    assign all_word  = {clamp8(i_green), clamp8(i_red), clamp8(i_blue)};
    assign shifted   = {r_shift[COLOR_W-2:0], 1'b0};
    assign pix_plus1 = {1'b0, r_pix} + 9'd1;
    assign pix_plus2 = {1'b0, r_pix} + 9'd2;

    rlcs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (LED_COUNT)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_shift    = r_shift;
        n_bit      = r_bit;
        n_pix      = r_pix;
        n_valid    = r_valid;
        n_global   = r_global;
        n_first    = r_first;
        n_acc      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = i_pixel_index[ADDR_W-1:0];
        ram_wdata  = pix_word;
        ram_re     = 1'b0;
        ram_raddr  = ADDR_W'(1);
        start_word = r_first;

        if (accept) begin
            if (req == REQ_TICK) begin
                if (r_phase != PH_IDLE) begin
                    if (r_tick > TICK_W'(1)) begin
                        n_tick = r_tick - TICK_W'(1);
                    end else begin
                        case (r_phase)
                            PH_HIGH: begin
                                n_phase = PH_LOW;
                                n_tick  = r_shift[COLOR_W-1] ?
                                          at_least_one(TICK_W'(r_long_high)) :
                                          at_least_one(TICK_W'(r_long_low));
                            end
                            PH_LOW: begin
                                n_bit   = r_bit + BIT_CNT_W'(1);
                                n_shift = shifted;
                                n_phase = PH_HIGH;
                                n_tick  = shifted[COLOR_W-1] ?
                                          at_least_one(TICK_W'(r_long_high)) :
                                          at_least_one(TICK_W'(r_short_high));
                                if (r_bit == BIT_LAST) begin
                                    n_bit = '0;
                                    if (pix_plus1 >= LED_CNT) begin
                                        n_phase = PH_LATCH;
                                        n_tick  = at_least_one(r_latch);
                                    end else begin
                                        n_pix   = pix_plus1[7:0];
                                        n_shift = r_next;
                                        n_tick  = r_next[COLOR_W-1] ?
                                                  at_least_one(TICK_W'(r_long_high)) :
                                                  at_least_one(TICK_W'(r_short_high));
                                        // prefetch the pixel after the one now starting
                                        ram_re    = (pix_plus2 < LED_CNT);
                                        ram_raddr = pix_plus2[ADDR_W-1:0];
                                    end
                                end
                            end
                            PH_LATCH: begin
                                n_phase = PH_IDLE;
                                n_tick  = '0;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end else if (r_phase == PH_IDLE) begin
                n_acc = 1'b1;
                if (req == REQ_SET_PIXEL) begin
                    if ({1'b0, i_pixel_index} < LED_CNT) begin
                        ram_we = 1'b1;
                        n_valid[i_pixel_index[ADDR_W-1:0]] = 1'b1;
                        if (i_pixel_index == 8'd0) begin
                            n_first = pix_word;
                        end
                    end
                end else begin
                    if (req == REQ_SET_ALL) begin
                        n_global   = all_word;
                        n_valid    = '0;
                        n_first    = all_word;
                        start_word = all_word;
                    end
                    n_pix   = '0;
                    n_bit   = '0;
                    n_shift = start_word;
                    n_phase = PH_HIGH;
                    n_tick  = start_word[COLOR_W-1] ?
                              at_least_one(TICK_W'(r_long_high)) :
                              at_least_one(TICK_W'(r_short_high));
                    ram_re    = (LED_COUNT > 1);
                    ram_raddr = ADDR_W'(1);
                end
            end
        end
    end

    // result fields
    always_comb begin
        n_line = (n_phase == PH_HIGH);
        n_busy = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_high <= 16'd30;
            r_long_high  <= 16'd60;
            r_long_low   <= 16'd90;
            r_latch      <= 24'd100000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHORT_HIGH: r_short_high <= i_cfg_data[DUR_W-1:0];
                CFG_LONG_HIGH:  r_long_high  <= i_cfg_data[DUR_W-1:0];
                CFG_LONG_LOW:   r_long_low   <= i_cfg_data[DUR_W-1:0];
                CFG_LATCH:      r_latch      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_shift     <= '0;
            r_bit       <= '0;
            r_pix       <= '0;
            r_valid     <= '0;
            r_global    <= '0;
            r_first     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_shift   <= n_shift;
            r_bit     <= n_bit;
            r_pix     <= n_pix;
            r_valid   <= n_valid;
            r_global  <= n_global;
            r_first   <= n_first;
            r_rd_pend <= ram_re;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_rd_addr <= ram_raddr;
        end
        if (r_rd_pend) begin
            r_next <= r_valid[r_rd_addr] ? ram_rdata : r_global;
        end
        if (accept) begin
            r_out_line <= n_line;
            r_out_busy <= n_busy;
            r_out_acc  <= n_acc;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_level = r_out_line;
    assign o_busy_res   = r_out_busy;
    assign o_accepted   = r_out_acc;

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= BIT_LAST)
        else $error("bit counter past last bit of a pixel");

    a_pix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pix} < LED_CNT)
        else $error("pixel counter beyond chain length");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick == '0))
        else $error("tick counter running while idle");

    a_busy_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_tick != '0))
        else $error("active phase with empty tick counter");

endmodule

`default_nettype wire

>>> dv/rlcs_checker.sv
// Checker for the RGB LED chain serializer: mirrors the chain timing and compares result beats.
`timescale 1ns / 100ps

module rlcs_checker #(
    parameter int LED_COUNT = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [1:0]                        i_req_type,
    input  logic [7:0]                        i_pixel_index,
    input  logic [15:0]                       i_red,
    input  logic [15:0]                       i_green,
    input  logic [15:0]                       i_blue,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_line_level,
    input  logic                              i_busy_res,
    input  logic                              i_accepted,
    input  logic                              i_cfg_we,
    input  logic [rlcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rlcs_pkg::TICK_W-1:0]       i_cfg_data,
    output int                                o_fail_count,
    output int                                o_results_owed,
    output logic                              o_frame_active
);
    import rlcs_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic line_level;
        logic busy;
        logic accepted;
    } t_line_beat;

    t_line_beat  expected_beats[$];
    int          fails = 0;

    // mirror of the block state
    logic [23:0] color_mem [LED_COUNT];
    logic [23:0] shift_word = '0;
    logic [7:0]  pix_cnt = '0;
    logic [4:0]  bit_cnt = '0;
    t_phase      ph = PH_IDLE;
    logic [23:0] ticks_left = '0;

    // timing registers
    logic [15:0] short_high = 16'd30;
    logic [15:0] long_high = 16'd60;
    logic [15:0] long_low = 16'd90;
    logic [23:0] latch_len = 24'd100000;

    assign o_fail_count   = fails;
    assign o_results_owed = expected_beats.size();
    assign o_frame_active = (ph != PH_IDLE);

    function automatic logic [23:0] nonzero_ticks(input logic [23:0] v);
        return v | {23'd0, (v == 24'd0)};
    endfunction

    function automatic logic [7:0] sat_channel(input logic signed [15:0] v);
        if (v < 0)
            return 8'h00;
        if (v > 16'sd255)
            return 8'hFF;
        return v[7:0];
    endfunction

    function automatic void reset_model();
        short_high = 16'd30;
        long_high  = 16'd60;
        long_low   = 16'd90;
        latch_len  = 24'd100000;
        for (int n = 0; n < LED_COUNT; n++)
            color_mem[n] = '0;
        shift_word = '0;
        pix_cnt    = '0;
        bit_cnt    = '0;
        ph         = PH_IDLE;
        ticks_left = '0;
    endfunction

    // high time depends on the bit now at the top of the shift word
    function automatic void begin_bit();
        ph = PH_HIGH;
        ticks_left = nonzero_ticks(24'(shift_word[23] ? long_high : short_high));
    endfunction

    function automatic void advance_tick();
        if (ph == PH_IDLE)
            return;
        if (ticks_left > 24'd1) begin
            ticks_left = ticks_left - 24'd1;
            return;
        end
        case (ph)
            PH_HIGH: begin
                ph = PH_LOW;
                ticks_left = nonzero_ticks(24'(shift_word[23] ? long_high : long_low));
            end
            PH_LOW: begin
                shift_word = shift_word << 1;
                bit_cnt = bit_cnt + 5'd1;
                if (bit_cnt >= 5'd24) begin
                    bit_cnt = '0;
                    if (32'(pix_cnt) + 1 >= LED_COUNT) begin
                        ph = PH_LATCH;
                        ticks_left = nonzero_ticks(latch_len);
                        return;
                    end
                    pix_cnt = pix_cnt + 8'd1;
                    shift_word = color_mem[pix_cnt];
                end
                begin_bit();
            end
            default: begin
                ph = PH_IDLE;
                ticks_left = '0;
            end
        endcase
    endfunction

    function automatic void predict_beat(input t_req req, input logic [7:0] idx,
                                         input logic [15:0] r, input logic [15:0] g,
                                         input logic [15:0] b);
        t_line_beat  beat;
        logic [23:0] fill;
        beat.accepted = 1'b0;
        if (req == REQ_TICK) begin
            advance_tick();
        end else if (ph == PH_IDLE) begin
            beat.accepted = 1'b1;
            if (req == REQ_SET_PIXEL) begin
                if (32'(idx) < LED_COUNT)
                    color_mem[idx] = {g[7:0], r[7:0], b[7:0]};
            end else begin
                if (req == REQ_SET_ALL) begin
                    fill = {sat_channel(g), sat_channel(r), sat_channel(b)};
                    for (int n = 0; n < LED_COUNT; n++)
                        color_mem[n] = fill;
                end
                pix_cnt = '0;
                bit_cnt = '0;
                shift_word = color_mem[0];
                begin_bit();
            end
        end
        beat.line_level = (ph == PH_HIGH);
        beat.busy = (ph != PH_IDLE);
        expected_beats.push_back(beat);
    endfunction

    always @(posedge i_clk) begin
        t_line_beat want;
        if (!i_rst_n) begin
            reset_model();
            expected_beats.delete();
        end else begin
            // result first: a beat taken now never belongs to a request taken now
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: result beat with none expected: line=%0b busy=%0b acc=%0b",
                                 $time, i_line_level, i_busy_res, i_accepted);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_line_level !== want.line_level || i_busy_res !== want.busy ||
                        i_accepted !== want.accepted) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("%0t: mismatch: exp line=%0b busy=%0b acc=%0b, got %0b %0b %0b",
                                     $time, want.line_level, want.busy, want.accepted,
                                     i_line_level, i_busy_res, i_accepted);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SHORT_HIGH: short_high = i_cfg_data[15:0];
                    CFG_LONG_HIGH:  long_high  = i_cfg_data[15:0];
                    CFG_LONG_LOW:   long_low   = i_cfg_data[15:0];
                    CFG_LATCH:      latch_len  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_beat(t_req'(i_req_type), i_pixel_index, i_red, i_green, i_blue);
        end
    end

endmodule

>>> dv/rgb_led_chain_serializer_tb.sv
// Testbench top for the RGB LED chain serializer: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module rgb_led_chain_serializer_tb;
    import rlcs_pkg::*;

    localparam int LED_COUNT   = 3;
    localparam int HALF_PERIOD = 5;
    localparam int TIMEOUT_NS  = 2_000_000;

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } t_fill;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           req_type = REQ_TICK;
    logic [7:0]           pixel_index = '0;
    logic signed [15:0]   red = '0;
    logic signed [15:0]   green = '0;
    logic signed [15:0]   blue = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 line_level;
    logic                 busy_res;
    logic                 accepted;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_SHORT_HIGH;
    logic [TICK_W-1:0]    cfg_data = '0;

    int   fail_count;
    int   results_owed;
    logic frame_active;
    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    int   items_sent = 0;

    rgb_led_chain_serializer #(.LED_COUNT(LED_COUNT)) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_req_type    (req_type),
        .i_pixel_index (pixel_index),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_line_level  (line_level),
        .o_busy_res    (busy_res),
        .o_accepted    (accepted),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    rlcs_checker #(.LED_COUNT(LED_COUNT)) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_pixel_index  (pixel_index),
        .i_red          (red),
        .i_green        (green),
        .i_blue         (blue),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_line_level   (line_level),
        .i_busy_res     (busy_res),
        .i_accepted     (accepted),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_results_owed (results_owed),
        .o_frame_active (frame_active)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_req(input t_req req, input logic [7:0] idx, input logic [15:0] r,
                            input logic [15:0] g, input logic [15:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        pixel_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_tick();
        send_req(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0)
            @(negedge clk);
    endtask

    // upper data bits are junk on the 16-bit registers
    task automatic load_timing(input logic [15:0] sh, input logic [15:0] lh,
                               input logic [15:0] ll, input logic [23:0] lat);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SHORT_HIGH;
        cfg_data <= {8'($urandom), sh};
        @(negedge clk);
        cfg_idx  <= CFG_LONG_HIGH;
        cfg_data <= {8'($urandom), lh};
        @(negedge clk);
        cfg_idx  <= CFG_LONG_LOW;
        cfg_data <= {8'($urandom), ll};
        @(negedge clk);
        cfg_idx  <= CFG_LATCH;
        cfg_data <= lat;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [15:0] pick_color();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 300));
            1: begin
                case ($urandom_range(0, 5))
                    0: return 16'h8000;
                    1: return 16'hFFFF;
                    2: return 16'h0000;
                    3: return 16'h00FF;
                    4: return 16'h0100;
                    default: return 16'h7FFF;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 9) < 8)
            return 8'($urandom_range(0, LED_COUNT - 1));
        if ($urandom_range(0, 1) == 0)
            return 8'(LED_COUNT);
        return 8'($urandom);
    endfunction

    // tick the frame out; now and then a request that must be refused, or a full drain
    task automatic tick_out();
        while (frame_active) begin
            if ($urandom_range(0, 99) < 4)
                send_req(t_req'($urandom_range(0, 2)), 8'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
            else if ($urandom_range(0, 999) < 3)
                drain_results();
            else
                send_tick();
        end
    endtask

    task automatic run_frame(input t_fill mode);
        if (mode == FILL_RANDOM)
            repeat ($urandom_range(0, 4))
                send_req(REQ_SET_PIXEL, pick_index(), pick_color(), pick_color(), pick_color());
        repeat ($urandom_range(0, 2))
            send_tick();
        case (mode)
            FILL_ONES:
                send_req(REQ_SET_ALL, 8'($urandom), 16'($urandom_range(255, 32767)),
                         16'($urandom_range(255, 32767)), 16'($urandom_range(255, 32767)));
            FILL_ZEROS:
                send_req(REQ_SET_ALL, 8'($urandom), 16'h8000 | 16'($urandom),
                         16'h8000 | 16'($urandom), 16'h8000 | 16'($urandom));
            default:
                if ($urandom_range(0, 1) == 0)
                    send_req(REQ_SHOW, 8'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
                else
                    send_req(REQ_SET_ALL, 8'($urandom), pick_color(), pick_color(),
                             pick_color());
        endcase
        tick_out();
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input int budget,
                             input t_fill mode);
        int start;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start = items_sent;
        while (items_sent - start < budget)
            run_frame(mode);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle behavior at reset timing
        send_tick();
        send_req(REQ_SET_PIXEL, 8'd0, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_req(REQ_SET_PIXEL, 8'd1, 16'h0100, 16'h00FF, 16'h0000);
        send_req(REQ_SET_PIXEL, 8'd2, 16'hFFFF, 16'h1234, 16'h8001);
        send_req(REQ_SET_PIXEL, 8'(LED_COUNT), 16'h00AA, 16'h0055, 16'h00CC);
        send_req(REQ_SET_PIXEL, 8'd255, 16'h0011, 16'h0022, 16'h0033);
        send_tick();

        // zero durations count as one tick
        drain_results();
        load_timing(16'd0, 16'd0, 16'd0, 24'd0);
        send_req(REQ_SHOW, 8'd0, 16'd0, 16'd0, 16'd0);
        send_req(REQ_SET_PIXEL, 8'd0, 16'h00FF, 16'h00FF, 16'h00FF);
        send_req(REQ_SET_ALL, 8'd0, 16'h00FF, 16'h00FF, 16'h00FF);
        send_req(REQ_SHOW, 8'd0, 16'd0, 16'd0, 16'd0);
        tick_out();
        send_req(REQ_SET_ALL, 8'd0, 16'sh8000, 16'sh7FFF, 16'h0100);
        tick_out();
        send_req(REQ_SET_ALL, 8'd0, 16'h00FF, 16'hFFFF, 16'h0000);
        tick_out();

        drain_results();
        load_timing(16'd1, 16'd2, 16'd1, 24'd3);
        run_phase(0, 0, 150, FILL_RANDOM);

        drain_results();
        load_timing(16'd2, 16'd1, 16'd3, 24'd4);
        run_phase(65, 0, 150, FILL_RANDOM);

        drain_results();
        load_timing(16'd1, 16'd3, 16'd2, 24'd1);
        run_phase(0, 65, 150, FILL_RANDOM);

        drain_results();
        load_timing(16'd3, 16'd2, 16'd1, 24'd7);
        run_phase(25, 25, 150, FILL_RANDOM);

        // all-ones frames never touch the short-high or long-low counts
        drain_results();
        load_timing(16'hFFFF, 16'd1, 16'hFFFF, 24'd1);
        run_phase(0, 0, 120, FILL_ONES);

        // all-zero frames never touch the long-high count
        drain_results();
        load_timing(16'd1, 16'hFFFF, 16'd1, 24'd2);
        run_phase(25, 25, 120, FILL_ZEROS);

        // largest settings: only idle traffic, a frame would run far too long
        drain_results();
        load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        src_idle_pct   = 65;
        sink_stall_pct = 65;
        repeat (30) begin
            if ($urandom_range(0, 1) == 0)
                send_req(REQ_SET_PIXEL, pick_index(), pick_color(), pick_color(), pick_color());
            else
                send_tick();
        end

        drain_results();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
